// ===== hw/rtl/tcsc_pkg.sv =====
// Shared types and constants for the tile cache with second-chance trimming.
// No dependencies; imported by every module of the block.
package tcsc_pkg;

  // Default number of table entries
  localparam int TABLE_ENTRIES_DEFAULT = 64;

  // Byte budget after reset
  localparam logic [31:0] MAX_BYTES_RESET = 32'd268435456;

  // Saturation limit of the eviction count
  localparam logic [6:0] CNT_MAX = 7'd127;

  // Trim kinds reported with each result
  localparam logic [1:0] TRIM_NONE  = 2'd0;
  localparam logic [1:0] TRIM_AGE   = 2'd1;
  localparam logic [1:0] TRIM_EVICT = 2'd2;

  // Item function codes
  localparam logic FUNC_DECLARE = 1'b0;
  localparam logic FUNC_ACCESS  = 1'b1;

  // Tile key: {x, y, z}
  typedef logic [47:0] key_t;

  // Per-entry status bits
  typedef struct packed {
    logic valid;
    logic loaded;
    logic used;
  } flags_t;

  // Table write enables
  typedef struct packed {
    logic flags_we;
    logic key_we;
    logic size_we;
  } wr_en_t;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ===== hw/rtl/tcsc_alu.sv =====
// Shared 32-bit saturating add/subtract and magnitude compare unit.
// Depends on tcsc_pkg for the operation type.
module tcsc_alu (
  input  tcsc_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       res,
  output logic              gt
);
  import tcsc_pkg::*;

  logic [32:0] sum;
  logic [32:0] diff;

  // Form carry-extended sum and difference
  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  // Clamp at the top on add, at zero on subtract
  always_comb begin
    unique case (op)
      ALU_ADD: res = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      ALU_SUB: res = diff[32] ? 32'd0 : diff[31:0];
      default: res = sum[31:0];
    endcase
  end

  assign gt = (a > b);

endmodule

// ===== hw/rtl/tcsc_table.sv =====
// Entry storage: status bits, tile keys and tile sizes, one write port and
// one registered read port. Depends on tcsc_pkg.
module tcsc_table #(
  parameter int TABLE_ENTRIES = tcsc_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  output tcsc_pkg::flags_t    rd_flags,
  output tcsc_pkg::key_t      rd_key,
  output logic [31:0]         rd_size,
  input  tcsc_pkg::wr_en_t    wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  tcsc_pkg::flags_t    wr_flags,
  input  tcsc_pkg::key_t      wr_key,
  input  logic [31:0]         wr_size
);
  import tcsc_pkg::*;

  flags_t      flag_mem [TABLE_ENTRIES];
  key_t        key_mem  [TABLE_ENTRIES];
  logic [31:0] size_mem [TABLE_ENTRIES];

  // Write selected fields of one entry
  always_ff @(posedge clk) begin
    if (wr_en.flags_we) begin
      flag_mem[wr_addr] <= wr_flags;
    end
    if (wr_en.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_en.size_we) begin
      size_mem[wr_addr] <= wr_size;
    end
  end

  // Register the read of one entry
  always_ff @(posedge clk) begin
    rd_flags <= flag_mem[rd_addr];
    rd_key   <= key_mem[rd_addr];
    rd_size  <= size_mem[rd_addr];
  end

endmodule

// ===== hw/rtl/tile_cache_second_chance_trim_top.sv =====
// Top level of the tile cache with second-chance trimming: sequencer, byte
// counters and result register. Depends on tcsc_pkg, tcsc_table, tcsc_alu.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_stall  | func, tile_x, tile_y, tile_z, tile_bytes
//   out      | out_valid / out_stall| found, loaded_now, trim_kind,
//            |                      | evicted_count, total_bytes, table_full
//   cfg      | cfg_valid / cfg_ready| max_cache_bytes
//
// With N = TABLE_ENTRIES, every item walks the table once for lookup through
// the single read port. A load adds two adds and up to two compares on the
// shared arithmetic unit, and a trim walks the table again. After reset a
// clearing pass over all N entries runs before the first item is taken. A
// result held by out_stall waits in the output register; the next item is
// taken meanwhile and its result waits until the register is free.
// Configuration writes are taken every cycle.
module tile_cache_second_chance_trim_top #(
  parameter int TABLE_ENTRIES = tcsc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [15:0] tile_x,
  input  logic signed [15:0] tile_y,
  input  logic signed [15:0] tile_z,
  input  logic [31:0]        tile_bytes,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic               loaded_now,
  output logic [1:0]         trim_kind,
  output logic [6:0]         evicted_count,
  output logic [31:0]        total_bytes,
  output logic               table_full,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        max_cache_bytes
);
  import tcsc_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_APPLY = 4'd3;
  localparam logic [3:0] S_ADD2  = 4'd4;
  localparam logic [3:0] S_CHK1  = 4'd5;
  localparam logic [3:0] S_CHK2  = 4'd6;
  localparam logic [3:0] S_TRIM  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]    state;
  logic [AW-1:0] scan;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] hit_idx;
  logic [AW-1:0] free_idx;
  logic          issuing;
  logic          rd_live;
  logic          evict_mode;
  logic          have_free;
  logic          hit_loaded;

  logic          item_func;
  key_t          item_key;
  logic [31:0]   item_bytes;

  logic [31:0]   max_bytes;
  logic [31:0]   loaded_total;
  logic [31:0]   since_bytes;

  logic          r_found;
  logic          r_loaded_now;
  logic [1:0]    r_trim_kind;
  logic [6:0]    r_evict_cnt;
  logic          r_full;

  flags_t        rd_flags;
  key_t          rd_key;
  logic [31:0]   rd_size;
  wr_en_t        wr_en;
  logic [AW-1:0] wr_addr;
  flags_t        wr_flags;

  alu_op_t       alu_op;
  logic [31:0]   alu_a;
  logic [31:0]   alu_b;
  logic [31:0]   alu_res;
  logic          alu_gt;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  tcsc_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rd_addr (scan),
    .rd_flags(rd_flags),
    .rd_key  (rd_key),
    .rd_size (rd_size),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_flags(wr_flags),
    .wr_key  (item_key),
    .wr_size (item_bytes)
  );

  tcsc_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .res(alu_res),
    .gt (alu_gt)
  );

  // Steer table writes and arithmetic operands by state
  always_comb begin
    wr_en    = '0;
    wr_addr  = scan;
    wr_flags = '0;
    alu_op   = ALU_ADD;
    alu_a    = loaded_total;
    alu_b    = item_bytes;
    unique case (state)
      S_CLEAR: begin
        wr_en.flags_we = 1'b1;
      end
      S_APPLY: begin
        if (item_func == FUNC_DECLARE) begin
          if (!r_found && have_free) begin
            wr_en.flags_we  = 1'b1;
            wr_en.key_we    = 1'b1;
            wr_addr         = free_idx;
            wr_flags.valid  = 1'b1;
          end
        end else if (r_found) begin
          wr_en.flags_we  = 1'b1;
          wr_en.size_we   = !hit_loaded;
          wr_addr         = hit_idx;
          wr_flags.valid  = 1'b1;
          wr_flags.loaded = 1'b1;
          wr_flags.used   = 1'b1;
        end
      end
      S_ADD2: begin
        alu_a = since_bytes;
      end
      S_CHK1: begin
        alu_b = max_bytes;
      end
      S_CHK2: begin
        alu_a = since_bytes;
        alu_b = max_bytes >> 1;
      end
      S_TRIM: begin
        alu_op  = ALU_SUB;
        alu_b   = rd_size;
        wr_addr = rd_idx;
        if (rd_live && rd_flags.valid) begin
          // Age a marked entry; in evict mode, unload an unmarked loaded one
          if (rd_flags.used) begin
            wr_en.flags_we  = 1'b1;
            wr_flags.valid  = 1'b1;
            wr_flags.loaded = rd_flags.loaded;
          end else if (evict_mode && rd_flags.loaded) begin
            wr_en.flags_we = 1'b1;
            wr_flags.valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan         <= '0;
      issuing      <= 1'b0;
      rd_live      <= 1'b0;
      out_valid    <= 1'b0;
      max_bytes    <= MAX_BYTES_RESET;
      loaded_total <= '0;
      since_bytes  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_bytes <= max_cache_bytes;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      rd_idx  <= scan;
      rd_live <= issuing;

      unique case (state)
        S_CLEAR: begin
          scan <= scan + 1'b1;
          if (scan == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_func    <= func;
            item_key     <= {tile_x, tile_y, tile_z};
            item_bytes   <= tile_bytes;
            r_found      <= 1'b0;
            r_loaded_now <= 1'b0;
            r_trim_kind  <= TRIM_NONE;
            r_evict_cnt  <= '0;
            r_full       <= 1'b0;
            have_free    <= 1'b0;
            hit_loaded   <= 1'b0;
            scan         <= '0;
            issuing      <= 1'b1;
            state        <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (issuing) begin
            scan <= scan + 1'b1;
            if (scan == LAST) begin
              issuing <= 1'b0;
            end
          end
          // Match the key, note the lowest free entry
          if (rd_live) begin
            if (rd_flags.valid && rd_key == item_key) begin
              r_found    <= 1'b1;
              hit_idx    <= rd_idx;
              hit_loaded <= rd_flags.loaded;
            end else if (!rd_flags.valid && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= rd_idx;
            end
            if (rd_idx == LAST) begin
              state <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          if (item_func == FUNC_DECLARE) begin
            if (!r_found && !have_free) begin
              r_full <= 1'b1;
            end
            state <= S_DONE;
          end else if (r_found && !hit_loaded) begin
            loaded_total <= alu_res;
            r_loaded_now <= 1'b1;
            state        <= S_ADD2;
          end else begin
            state <= S_DONE;
          end
        end
        S_ADD2: begin
          since_bytes <= alu_res;
          state       <= S_CHK1;
        end
        S_CHK1: begin
          if (alu_gt) begin
            r_trim_kind <= TRIM_EVICT;
            evict_mode  <= 1'b1;
            scan        <= '0;
            issuing     <= 1'b1;
            state       <= S_TRIM;
          end else begin
            state <= S_CHK2;
          end
        end
        S_CHK2: begin
          if (alu_gt) begin
            since_bytes <= '0;
            r_trim_kind <= TRIM_AGE;
            evict_mode  <= 1'b0;
            scan        <= '0;
            issuing     <= 1'b1;
            state       <= S_TRIM;
          end else begin
            state <= S_DONE;
          end
        end
        S_TRIM: begin
          if (issuing) begin
            scan <= scan + 1'b1;
            if (scan == LAST) begin
              issuing <= 1'b0;
            end
          end
          // Subtract the size of an evicted entry and count it
          if (rd_live) begin
            if (rd_flags.valid && !rd_flags.used && evict_mode && rd_flags.loaded) begin
              loaded_total <= alu_res;
              if (r_evict_cnt != CNT_MAX) begin
                r_evict_cnt <= r_evict_cnt + 1'b1;
              end
            end
            if (rd_idx == LAST) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // Hand over the result once the output register is free
          if (!out_valid || !out_stall) begin
            found         <= r_found;
            loaded_now    <= r_loaded_now;
            trim_kind     <= r_trim_kind;
            evicted_count <= r_evict_cnt;
            total_bytes   <= loaded_total;
            table_full    <= r_full;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
